// ===== rtl/tar_pkg.sv =====
// shared constants and types for the tile animation remapper
`timescale 1ns / 1ps
package tar_pkg;
   localparam int NumTilesDefault   = 1024;
   localparam int NumStrandsDefault = 16;
   localparam int TileW   = 10;
   localparam int DelayW  = 16;
   localparam int SelW    = 4;
   localparam int CountW  = 5;
   localparam logic [15:0] LfsrSeed = 16'hACE1;
   localparam logic [15:0] LfsrMask = 16'hB400;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_RESET = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      MODE_FWD  = 2'd0,
      MODE_BWD  = 2'd1,
      MODE_FLIP = 2'd2,
      MODE_RAND = 2'd3
   } mode_type;

   // one strand's settings as stored
   typedef struct packed {
      logic [DelayW-1:0] delay;
      logic [1:0]        mode;
      logic [TileW-1:0]  first;
      logic [TileW-1:0]  last;
   } strand_type;
endpackage

// ===== rtl/tar_mod.sv =====
// multi-cycle modulo unit, restoring, one quotient bit per cycle
`timescale 1ns / 1ps
module tar_mod (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [15:0]             dividend,
   input  logic [tar_pkg::TileW-1:0] divisor,
   output logic                    done,
   output logic [tar_pkg::TileW-1:0] remainder
);
   logic [15:0]              num_ff, num_in;
   logic [tar_pkg::TileW:0]  rem_ff, rem_in;
   logic [4:0]               cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic [tar_pkg::TileW:0]  trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[tar_pkg::TileW-1:0], num_ff[15]};
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         cnt_in  = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[14:0], 1'b0};
         if (trial >= {1'b0, divisor}) rem_in = trial - {1'b0, divisor};
         else rem_in = trial;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done      = busy_ff && (cnt_ff == 5'd1);
   assign remainder = done ? rem_in[tar_pkg::TileW-1:0] : rem_ff[tar_pkg::TileW-1:0];
endmodule

// ===== rtl/tile_animation_remapper.sv =====
// top level of the tile animation remapper
`timescale 1ns / 1ps
// Tile animation remapper. One item in, one item out, in order. The tile map
// lives in a synchronous memory; strand settings and countdowns live in small
// register files. After reset, and after each restart item, a clearing pass
// writes the identity into the map at one entry per cycle before the next
// item is taken. A tick visits each active strand; each strand that fires
// steps its map entries, each through read, wait and write, and in random
// mode through the bit-serial modulo unit between wait and write.
// The result is written into the output register in the item's last state; a
// restart's result is written when it is taken, ahead of its clearing pass.
// A finished item waiting in the output register holds off the next item
// until rsp_ready is high.
module tile_animation_remapper #(
   parameter int NUM_TILES   = tar_pkg::NumTilesDefault,
   parameter int NUM_STRANDS = tar_pkg::NumStrandsDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [tar_pkg::CountW-1:0] csr_active_strands,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_func,
   input  logic [tar_pkg::SelW-1:0]   req_strand_sel,
   input  logic [15:0]                req_delay_ticks,
   input  logic [1:0]                 req_anim_mode,
   input  logic [9:0]                 req_first_tile,
   input  logic [9:0]                 req_last_tile,
   input  logic [9:0]                 req_tile_query,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [9:0]                 rsp_mapped_tile,
   output logic                       rsp_read_valid
);
   localparam int TW  = tar_pkg::TileW;
   localparam int SW  = (NUM_STRANDS > 1) ? $clog2(NUM_STRANDS) : 1;
   localparam int MW  = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
   localparam int IW  = MW + 1;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_READW = 9'b000000100,
      ST_STRND = 9'b000001000,
      ST_ERD   = 9'b000010000,
      ST_EWAIT = 9'b000100000,
      ST_EMOD  = 9'b001000000,
      ST_EWR   = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // tile map memory
   logic [TW-1:0] map_mem [NUM_TILES];
   logic [TW-1:0] map_rd_ff;
   logic          map_we;
   logic [MW-1:0] map_waddr, map_raddr;
   logic [TW-1:0] map_wdata;

   // strand register files
   tar_pkg::strand_type    cfg_ff [NUM_STRANDS];
   logic [15:0]            cnt_ff [NUM_STRANDS];
   logic                   dir_ff [NUM_STRANDS];

   logic [tar_pkg::CountW-1:0] active_ff;
   logic [15:0]  lfsr_ff, lfsr_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [SW:0]   sidx_ff, sidx_in;
   logic [TW:0]   ent_ff, ent_in;
   logic [TW-1:0] cur_ff, cur_in;
   logic          out_v_ff;
   logic [TW-1:0] out_map_ff;
   logic          out_rv_ff;
   logic          done_set;
   logic [TW-1:0] done_map;
   logic          done_rv;
   logic          mod_busy_ff;
   logic [TW-1:0] req_tile_query_ff;

   logic [SW-1:0]       s;
   tar_pkg::strand_type sc;
   logic [SW:0]         nstr;
   logic                mod_start, mod_done;
   logic [TW-1:0]       mod_rem, mod_div;
   logic                dir_set, dir_val;
   logic                cnt_fire_wr, cnt_dec_wr;
   logic                load_wr, restart_wr;
   logic [TW:0]         nxt;

   assign s   = sidx_ff[SW-1:0];
   assign sc  = cfg_ff[s];
   // register values above the strand count act as the strand count
   assign nstr = (int'(active_ff) > NUM_STRANDS)
                 ? (SW+1)'(NUM_STRANDS) : (SW+1)'(active_ff);
   assign mod_div = sc.last - sc.first;

   tar_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (lfsr_ff),
      .divisor   (mod_div),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE) && (!out_v_ff || rsp_ready);
   assign rsp_valid       = out_v_ff;
   assign rsp_mapped_tile = out_map_ff;
   assign rsp_read_valid  = out_rv_ff;

   always_comb begin
      state_in    = state_ff;
      lfsr_in     = lfsr_ff;
      clr_in      = clr_ff;
      sidx_in     = sidx_ff;
      ent_in      = ent_ff;
      cur_in      = cur_ff;
      map_we      = 1'b0;
      map_waddr   = clr_ff[MW-1:0];
      map_wdata   = TW'(clr_ff);
      map_raddr   = req_tile_query[MW-1:0];
      mod_start   = 1'b0;
      dir_set     = 1'b0;
      dir_val     = 1'b0;
      cnt_fire_wr = 1'b0;
      cnt_dec_wr  = 1'b0;
      load_wr     = 1'b0;
      restart_wr  = 1'b0;
      done_set    = 1'b0;
      done_map    = '0;
      done_rv     = 1'b0;
      nxt         = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            // identity fill, one entry per cycle
            map_we = 1'b1;
            clr_in = clr_ff + IW'(1);
            if (clr_ff == IW'(NUM_TILES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               unique case (tar_pkg::func_type'(req_func))
                  tar_pkg::FUNC_TICK: begin
                     sidx_in  = '0;
                     state_in = ST_STRND;
                  end
                  tar_pkg::FUNC_LOAD: begin
                     load_wr  = 1'b1;
                     done_set = 1'b1;
                  end
                  tar_pkg::FUNC_READ: state_in = ST_READW;
                  default: begin
                     restart_wr = 1'b1;
                     clr_in     = '0;
                     done_set   = 1'b1;
                     state_in   = ST_CLEAR;
                  end
               endcase
            end
         end
         ST_READW: begin
            done_set = 1'b1;
            done_rv  = ({1'b0, req_tile_query_ff} < (TW+1)'(NUM_TILES)) ||
                       (NUM_TILES > 1023);
            done_map = done_rv ? map_rd_ff : '0;
            state_in = ST_IDLE;
         end
         ST_STRND: begin
            if (sidx_ff >= nstr) begin
               done_set = 1'b1;
               state_in = ST_IDLE;
            end else if (cnt_ff[s] > 16'd1) begin
               cnt_dec_wr = 1'b1;
               sidx_in    = sidx_ff + (SW+1)'(1);
            end else begin
               cnt_fire_wr = 1'b1;
               ent_in      = {1'b0, sc.first};
               state_in    = ST_ERD;
            end
         end
         ST_ERD: begin
            if (ent_ff >= {1'b0, sc.last} || ent_ff >= (TW+1)'(NUM_TILES) &&
                NUM_TILES <= 1024) begin
               sidx_in  = sidx_ff + (SW+1)'(1);
               state_in = ST_STRND;
            end else begin
               map_raddr = ent_ff[MW-1:0];
               state_in  = ST_EWAIT;
            end
         end
         ST_EWAIT: begin
            cur_in = map_rd_ff;
            if (tar_pkg::mode_type'(sc.mode) == tar_pkg::MODE_RAND) begin
               lfsr_in   = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? tar_pkg::LfsrMask : 16'h0);
               state_in  = ST_EMOD;
            end else begin
               state_in = ST_EWR;
            end
         end
         ST_EMOD: begin
            if (!mod_busy_ff) mod_start = 1'b1;
            if (mod_done) begin
               cur_in   = sc.first + mod_rem;
               state_in = ST_EWR;
            end
         end
         ST_EWR: begin
            map_we    = 1'b1;
            map_waddr = ent_ff[MW-1:0];
            map_wdata = cur_ff;
            unique case (tar_pkg::mode_type'(sc.mode))
               tar_pkg::MODE_FWD: begin
                  nxt = {1'b0, cur_ff} + (TW+1)'(1);
                  map_wdata = (nxt > {1'b0, sc.last}) ? sc.first : nxt[TW-1:0];
               end
               tar_pkg::MODE_BWD: begin
                  map_wdata = (cur_ff <= sc.first) ? sc.last : cur_ff - TW'(1);
               end
               tar_pkg::MODE_FLIP: begin
                  if (dir_ff[s]) begin
                     if (cur_ff <= sc.first) begin
                        dir_set = 1'b1;
                        dir_val = 1'b0;
                        map_wdata = sc.first;
                     end else map_wdata = cur_ff - TW'(1);
                  end else begin
                     nxt = {1'b0, cur_ff} + (TW+1)'(1);
                     if (nxt > {1'b0, sc.last}) begin
                        dir_set = 1'b1;
                        dir_val = 1'b1;
                        map_wdata = sc.last;
                     end else map_wdata = nxt[TW-1:0];
                  end
               end
               default: map_wdata = cur_ff;
            endcase
            ent_in   = ent_ff + (TW+1)'(1);
            state_in = ST_ERD;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // modulo start only once per entry
   always_ff @(posedge clock) begin
      if (reset) mod_busy_ff <= 1'b0;
      else if (mod_done) mod_busy_ff <= 1'b0;
      else if (mod_start) mod_busy_ff <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_tile_query_ff <= req_tile_query;
   end

   // map memory
   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_waddr] <= map_wdata;
      map_rd_ff <= map_mem[map_raddr];
   end

   // strand register files
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STRANDS; i++) begin
            cfg_ff[i] <= '0;
            cnt_ff[i] <= '0;
            dir_ff[i] <= 1'b0;
         end
      end else begin
         if (restart_wr) begin
            for (int i = 0; i < NUM_STRANDS; i++) begin
               cnt_ff[i] <= cfg_ff[i].delay;
               dir_ff[i] <= 1'b0;
            end
         end
         if (load_wr && ({1'b0, req_strand_sel} < 5'(NUM_STRANDS) || NUM_STRANDS > 15)) begin
            cfg_ff[req_strand_sel[SW-1:0]] <= {req_delay_ticks, req_anim_mode,
                                              req_first_tile, req_last_tile};
            cnt_ff[req_strand_sel[SW-1:0]] <= req_delay_ticks;
            dir_ff[req_strand_sel[SW-1:0]] <= 1'b0;
         end
         if (cnt_dec_wr)  cnt_ff[s] <= cnt_ff[s] - 16'd1;
         if (cnt_fire_wr) cnt_ff[s] <= sc.delay;
         if (dir_set)     dir_ff[s] <= dir_val;
      end
   end

   // control registers and output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         lfsr_ff   <= tar_pkg::LfsrSeed;
         active_ff <= '0;
         out_v_ff  <= 1'b0;
         sidx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         lfsr_ff  <= lfsr_in;
         sidx_ff  <= sidx_in;
         if (csr_valid && csr_ready) active_ff <= csr_active_strands;
         if (done_set) out_v_ff <= 1'b1;
         else if (rsp_ready) out_v_ff <= 1'b0;
      end
      ent_ff <= ent_in;
      cur_ff <= cur_in;
      if (done_set) begin
         out_map_ff <= done_map;
         out_rv_ff  <= done_rv;
      end
   end
endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the tile animation remapper
`timescale 1ns / 1ps
module tb_top;
   // one request item as driven on the req_ ports
   typedef struct {
      tar_pkg::func_type func;
      logic [3:0]        sel;
      logic [15:0]       delay;
      tar_pkg::mode_type mode;
      logic [9:0]        first;
      logic [9:0]        last;
      logic [9:0]        query;
   } req_item_type;

   // one predicted response item
   typedef struct {
      logic [9:0] mapped;
      logic       rd_valid;
   } map_answer_type;

   // tracks the tile map and strands, and holds answers still awaited
   class remap_scoreboard;
      logic [9:0]        tile_map [1024];
      logic [15:0]       countdown [16];
      logic              dir_back [16];
      logic [15:0]       delay [16];
      tar_pkg::mode_type mode [16];
      logic [9:0]        first [16];
      logic [9:0]        last [16];
      logic [15:0]       lfsr;
      logic [4:0]        active;
      map_answer_type    pending [$];
      int                errors;

      function new();
         for (int s = 0; s < 16; s++) begin
            delay[s] = '0;
            mode[s]  = tar_pkg::MODE_FWD;
            first[s] = '0;
            last[s]  = '0;
         end
         lfsr   = tar_pkg::LfsrSeed;
         active = '0;
         errors = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 1024; i++) tile_map[i] = i[9:0];
         for (int s = 0; s < 16; s++) begin
            countdown[s] = delay[s];
            dir_back[s]  = 1'b0;
         end
      endfunction

      function void set_active(logic [4:0] v);
         active = v;
      endfunction

      // step entries first..last-1 of one strand in ascending order
      function void step_strand(int s);
         int f, l, cur;
         logic lsb;
         f = first[s];
         l = last[s];
         for (int j = f; j < l; j++) begin
            cur = tile_map[j];
            case (mode[s])
               tar_pkg::MODE_FWD: begin
                  cur++;
                  if (cur > l) cur = f;
               end
               tar_pkg::MODE_BWD: begin
                  cur--;
                  if (cur < f) cur = l;
               end
               tar_pkg::MODE_FLIP: begin
                  if (dir_back[s]) begin
                     cur--;
                     if (cur < f) begin
                        dir_back[s] = 1'b0;
                        cur = f;
                     end
                  end else begin
                     cur++;
                     if (cur > l) begin
                        dir_back[s] = 1'b1;
                        cur = l;
                     end
                  end
               end
               default: begin
                  lsb  = lfsr[0];
                  lfsr = lfsr >> 1;
                  if (lsb) lfsr = lfsr ^ tar_pkg::LfsrMask;
                  cur = f + (int'(lfsr) % (l - f));
               end
            endcase
            tile_map[j] = cur[9:0];
         end
      endfunction

      function void note_item(req_item_type it);
         map_answer_type a;
         int n;
         a.mapped   = '0;
         a.rd_valid = 1'b0;
         case (it.func)
            tar_pkg::FUNC_TICK: begin
               n = (active > 16) ? 16 : active;
               for (int s = 0; s < n; s++) begin
                  if (countdown[s] > 1) countdown[s]--;
                  else begin
                     countdown[s] = delay[s];
                     step_strand(s);
                  end
               end
            end
            tar_pkg::FUNC_LOAD: begin
               delay[it.sel]     = it.delay;
               mode[it.sel]      = it.mode;
               first[it.sel]     = it.first;
               last[it.sel]      = it.last;
               countdown[it.sel] = it.delay;
               dir_back[it.sel]  = 1'b0;
            end
            tar_pkg::FUNC_READ: begin
               a.mapped   = tile_map[it.query];
               a.rd_valid = 1'b1;
            end
            default: restart();
         endcase
         pending.push_back(a);
      endfunction

      function void check_result(logic [9:0] mapped, logic rd_valid);
         map_answer_type a;
         if (pending.size() == 0) begin
            $error("unexpected response item: mapped_tile %0d read_valid %0b",
                   mapped, rd_valid);
            errors++;
            return;
         end
         a = pending.pop_front();
         if (mapped !== a.mapped) begin
            $error("mapped_tile: expected %0d, actual %0d", a.mapped, mapped);
            errors++;
         end
         if (rd_valid !== a.rd_valid) begin
            $error("read_valid: expected %0b, actual %0b", a.rd_valid, rd_valid);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_valid;
   logic       csr_ready;
   logic [4:0] csr_active_strands;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_func;
   logic [3:0] req_strand_sel;
   logic [15:0] req_delay_ticks;
   logic [1:0] req_anim_mode;
   logic [9:0] req_first_tile;
   logic [9:0] req_last_tile;
   logic [9:0] req_tile_query;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [9:0] rsp_mapped_tile;
   logic       rsp_read_valid;

   remap_scoreboard sb;
   bit calm;        // last part of the run: no idling on either side
   bit hold_start;  // asks the receiver for one long hold-off

   tile_animation_remapper DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_active_strands (csr_active_strands),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_strand_sel     (req_strand_sel),
      .req_delay_ticks    (req_delay_ticks),
      .req_anim_mode      (req_anim_mode),
      .req_first_tile     (req_first_tile),
      .req_last_tile      (req_last_tile),
      .req_tile_query     (req_tile_query),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mapped_tile    (rsp_mapped_tile),
      .rsp_read_valid     (rsp_read_valid)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // present one item, hold it until taken, then maybe idle a burst
   task automatic send_item(req_item_type it);
      int gap;
      req_valid       <= 1'b1;
      req_func        <= it.func;
      req_strand_sel  <= it.sel;
      req_delay_ticks <= it.delay;
      req_anim_mode   <= it.mode;
      req_first_tile  <= it.first;
      req_last_tile   <= it.last;
      req_tile_query  <= it.query;
      do @(posedge clock); while (!req_ready);
      sb.note_item(it);
      gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering, wait for every awaited item, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // register write, to be called only while the block is idle; it drains first but does not enforce that
   task automatic write_active(logic [4:0] v);
      drain();
      csr_valid          <= 1'b1;
      csr_active_strands <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_active(v);
      csr_valid <= 1'b0;
   endtask

   function automatic req_item_type mk(tar_pkg::func_type f, int sel, int dly,
                                       tar_pkg::mode_type m, int fst, int lst, int q);
      req_item_type it;
      it.func  = f;
      it.sel   = sel[3:0];
      it.delay = dly[15:0];
      it.mode  = m;
      it.first = fst[9:0];
      it.last  = lst[9:0];
      it.query = q[9:0];
      return it;
   endfunction

   // random item: mostly small strand ranges and short delays
   function automatic req_item_type rand_item();
      req_item_type it;
      int pick, span, s, f, l;
      it  = mk(tar_pkg::FUNC_TICK, $urandom_range(0, 15), 0,
               tar_pkg::mode_type'($urandom_range(0, 3)),
               $urandom_range(0, 1023), 0, $urandom_range(0, 1023));
      pick = $urandom_range(0, 99);
      if (pick < 35) it.func = tar_pkg::FUNC_TICK;
      else if (pick < 60) begin
         it.func = tar_pkg::FUNC_LOAD;
         pick = $urandom_range(0, 9);
         it.delay = (pick < 7) ? 16'($urandom_range(0, 3)) :
                    (pick < 9) ? 16'($urandom_range(0, 20)) : 16'($urandom_range(0, 65535));
         f    = it.first;
         pick = $urandom_range(0, 199);
         if (pick == 0) begin
            // rare wide range, kept out of random mode to bound its cost
            it.first = 10'($urandom_range(0, 15));
            it.last  = 10'($urandom_range(1000, 1023));
            it.mode  = tar_pkg::mode_type'($urandom_range(0, 2));
         end else if (pick < 30) it.last = 10'($urandom_range(0, f));
         else begin
            span = $urandom_range(0, 12);
            l = (f + span > 1023) ? 1023 : f + span;
            it.last = l[9:0];
         end
      end else if (pick < 97) begin
         it.func = tar_pkg::FUNC_READ;
         if ($urandom_range(0, 1)) begin
            // aim at one strand's range
            s = $urandom_range(0, 15);
            f = sb.first[s];
            l = (sb.last[s] > sb.first[s]) ? sb.last[s] : sb.first[s];
            it.query = 10'($urandom_range(f, l));
         end
      end else it.func = tar_pkg::FUNC_RESET;
      return it;
   endfunction

   // response side: checks each item taken and idles in bursts
   initial begin : rsp_side
      int stall, hold;
      stall = 0;
      hold  = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_mapped_tile, rsp_read_valid);
         if (hold_start) begin
            hold_start = 1'b0;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(0, 12);
            rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
      end
   end

   // long fixed ceiling on the whole run
   initial begin : watchdog
      #1s;
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      logic [4:0] settings [7];
      sb = new();
      calm = 1'b0;
      hold_start = 1'b0;
      reset              <= 1'b1;
      csr_valid          <= 1'b0;
      csr_active_strands <= '0;
      req_valid          <= 1'b0;
      req_func           <= tar_pkg::FUNC_TICK;
      req_strand_sel     <= '0;
      req_delay_ticks    <= '0;
      req_anim_mode      <= tar_pkg::MODE_FWD;
      req_first_tile     <= '0;
      req_last_tile      <= '0;
      req_tile_query     <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset state: identity map and no strands walked
      send_item(mk(tar_pkg::FUNC_READ, 0, 0, tar_pkg::MODE_FWD, 0, 0, 0));
      send_item(mk(tar_pkg::FUNC_READ, 0, 0, tar_pkg::MODE_FWD, 0, 0, 1023));
      send_item(mk(tar_pkg::FUNC_TICK, 0, 0, tar_pkg::MODE_FWD, 0, 0, 0));

      write_active(5'd16);
      // each mode once, a delay of zero fires on every tick
      send_item(mk(tar_pkg::FUNC_LOAD, 0, 0, tar_pkg::MODE_FWD, 2, 5, 0));
      send_item(mk(tar_pkg::FUNC_LOAD, 1, 1, tar_pkg::MODE_BWD, 10, 13, 0));
      send_item(mk(tar_pkg::FUNC_LOAD, 2, 2, tar_pkg::MODE_FLIP, 20, 22, 0));
      send_item(mk(tar_pkg::FUNC_LOAD, 3, 0, tar_pkg::MODE_RAND, 30, 37, 0));
      // empty range and the top of every field
      send_item(mk(tar_pkg::FUNC_LOAD, 4, 0, tar_pkg::MODE_FWD, 40, 40, 0));
      send_item(mk(tar_pkg::FUNC_LOAD, 15, 65535, tar_pkg::MODE_RAND, 1023, 1023, 0));
      send_item(mk(tar_pkg::FUNC_LOAD, 5, 0, tar_pkg::MODE_FLIP, 1000, 1023, 0));
      for (int i = 0; i < 4; i++)
         send_item(mk(tar_pkg::FUNC_TICK, 0, 0, tar_pkg::MODE_FWD, 0, 0, 0));
      send_item(mk(tar_pkg::FUNC_READ, 0, 0, tar_pkg::MODE_FWD, 0, 0, 2));
      send_item(mk(tar_pkg::FUNC_READ, 0, 0, tar_pkg::MODE_FWD, 0, 0, 12));
      send_item(mk(tar_pkg::FUNC_READ, 0, 0, tar_pkg::MODE_FWD, 0, 0, 21));
      send_item(mk(tar_pkg::FUNC_READ, 0, 0, tar_pkg::MODE_FWD, 0, 0, 33));
      send_item(mk(tar_pkg::FUNC_READ, 0, 0, tar_pkg::MODE_FWD, 0, 0, 1022));
      // restart returns the map to identity and reloads counts
      send_item(mk(tar_pkg::FUNC_RESET, 0, 0, tar_pkg::MODE_FWD, 0, 0, 0));
      send_item(mk(tar_pkg::FUNC_READ, 0, 0, tar_pkg::MODE_FWD, 0, 0, 2));
      send_item(mk(tar_pkg::FUNC_LOAD, 5, 3, tar_pkg::MODE_FWD, 50, 52, 0));
      send_item(mk(tar_pkg::FUNC_TICK, 0, 0, tar_pkg::MODE_FWD, 0, 0, 0));

      settings[0] = 5'd31;
      settings[1] = 5'd1;
      settings[2] = 5'd0;
      settings[3] = 5'd16;
      settings[4] = 5'($urandom_range(2, 15));
      settings[5] = 5'd17;
      settings[6] = 5'($urandom_range(0, 31));
      for (int p = 0; p < 7; p++) begin
         write_active(settings[p]);
         if (p == 6) calm = 1'b1;
         for (int i = 0; i < 150; i++) begin
            if (p == 2 && i == 40) hold_start = 1'b1;
            if (p == 3 && i == 60) begin
               // sender waits for every awaited item before going on
               drain();
            end
            send_item(rand_item());
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
